// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the validator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("check failed");
`endif

// ===== rtl/sjv_pkg.sv =====
// Package for the strict JSON syntax validator: modes, codes, limits.
// No dependencies.
package sjv_pkg;
	localparam int STACK_DEPTH_DEF  = 32;
	localparam int STRING_LIMIT_DEF = 4096;

	typedef enum logic [4:0] {
		M_PRE = 5'd0, M_OBJ_OPEN = 5'd1, M_KEY_REQ = 5'd2, M_KEY = 5'd3,
		M_KEY_ESC = 5'd4, M_KEY_HEX = 5'd5, M_STR = 5'd6, M_STR_ESC = 5'd7,
		M_STR_HEX = 5'd8, M_COLON = 5'd9, M_VALUE = 5'd10, M_ARR_OPEN = 5'd11,
		M_LIT_T = 5'd12, M_LIT_F = 5'd13, M_LIT_N = 5'd14, M_NUM_SIGN = 5'd15,
		M_NUM_ZERO = 5'd16, M_NUM_INT = 5'd17, M_NUM_DOT = 5'd18,
		M_NUM_FRAC = 5'd19, M_NUM_E = 5'd20, M_NUM_ESIGN = 5'd21,
		M_NUM_EXP = 5'd22, M_AFTER = 5'd23, M_DONE = 5'd24
	} mode_t;

	typedef enum logic [3:0] {
		E_NONE = 4'd0, E_UNEXP = 4'd1, E_DEPTH = 4'd2, E_ELEMS = 4'd3,
		E_STRLONG = 4'd4, E_NUMLONG = 4'd5, E_CTRL = 4'd6, E_ESC = 4'd7,
		E_EARLY = 4'd8, E_TRAIL = 4'd9
	} err_t;

	typedef enum logic [1:0] {V_BUSY = 2'd0, V_OK = 2'd1, V_BAD = 2'd2} verdict_t;

	typedef enum logic [2:0] {
		R_MAX_DEPTH = 3'd0, R_MAX_ELEMS = 3'd1, R_VAL_MAX = 3'd2,
		R_KEY_MAX = 3'd3, R_NUM_MAX = 3'd4
	} reg_idx_t;

	// byte classes produced by the front part
	typedef struct packed {
		logic [7:0] c;
		logic       last;
		logic       ws;
		logic       digit;
		logic       hex_ok;
		logic [3:0] hex;
		logic       esc_simple;
		logic       ctrl;
	} cls_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [3:0] err;
		logic [5:0] depth;
		logic       done;
	} res_t;

	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
		logic [7:0] r;
		r = 8'h00;
		case (w)
			2'd0: case (p) 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e"; default: r = 8'h00; endcase
			2'd1: case (p) 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
				default: r = 8'h00; endcase
			2'd2: case (p) 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l"; default: r = 8'h00; endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] w);
		return (w == 2'd1) ? 3'd5 : 3'd4;
	endfunction
endpackage

// ===== rtl/sjv_front.sv =====
// Front part: accepts bytes and classifies them into a class record.
// Depends on sjv_pkg.
module sjv_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          ready,
	input  logic [7:0]    data_byte,
	input  logic          last,
	output logic          cls_valid,
	input  logic          cls_ready,
	output sjv_pkg::cls_t cls
);
	import sjv_pkg::*;
	cls_t c_d;
	logic [7:0] b;

	assign b = data_byte;
	always_comb begin
		c_d = '0;
		c_d.c = b;
		c_d.last = last;
		c_d.ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
		c_d.digit = (b >= "0") && (b <= "9");
		c_d.ctrl = (b < 8'h20);
		c_d.esc_simple = (b == "\"") || (b == "\\") || (b == "/") || (b == "b") ||
			(b == "f") || (b == "n") || (b == "r") || (b == "t");
		if (c_d.digit) begin
			c_d.hex_ok = 1'b1; c_d.hex = 4'(b - "0");
		end else if (b >= "a" && b <= "f") begin
			c_d.hex_ok = 1'b1; c_d.hex = 4'(b - "a" + 8'd10);
		end else if (b >= "A" && b <= "F") begin
			c_d.hex_ok = 1'b1; c_d.hex = 4'(b - "A" + 8'd10);
		end
	end

	assign ready = !cls_valid || cls_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid <= 1'b0;
		end else if (ready) begin
			cls_valid <= valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ready && valid) begin
			cls <= c_d;
		end
	end
endmodule

// ===== rtl/sjv_fifo.sv =====
// Two-entry queue between front and back parts.
// Depends on sjv_pkg.
module sjv_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sjv_pkg::cls_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sjv_pkg::cls_t out_data
);
	import sjv_pkg::*;
	cls_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule

// ===== rtl/sjv_back.sv =====
// Back part: parser state machine, container stack and result register.
// Depends on sjv_pkg.
module sjv_back #(
	parameter int STACK_DEPTH  = sjv_pkg::STACK_DEPTH_DEF,
	parameter int STRING_LIMIT = sjv_pkg::STRING_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sjv_pkg::cls_t cls,
	input  logic          cfg_valid,
	input  logic [2:0]    cfg_index,
	input  logic [12:0]   cfg_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sjv_pkg::res_t res
);
	import sjv_pkg::*;
	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	// registers are 13 bits, so a larger limit is clamped to 8191
	localparam logic [13:0] SLIM = 14'((STRING_LIMIT > 8191) ? 8191 : STRING_LIMIT);

	logic [5:0]  max_depth_q;
	logic [12:0] max_elems_q, val_max_q, key_max_q;
	logic [8:0]  num_max_q;

	logic        kind_mem [STACK_DEPTH];
	logic [12:0] cnt_mem  [STACK_DEPTH];

	mode_t       mode_q, mode_d;
	logic [6:0]  lvl_q, lvl_d;
	logic [13:0] slen_q, slen_d;
	logic [2:0]  hexl_q, hexl_d;
	logic [15:0] cu_q, cu_d;
	logic [9:0]  nlen_q, nlen_d;
	logic [2:0]  lpos_q, lpos_d;
	err_t        err_q, err_d;

	logic        wr_en;
	logic [SW-1:0] wr_idx;
	logic        wr_kind;
	logic [12:0] wr_cnt;

	logic        top_ok, kind_top;
	logic [SW-1:0] top_idx;
	logic [12:0] cnt_top;
	logic        fire;
	logic [7:0]  c;

	assign fire = in_valid && in_ready;
	assign in_ready = !out_valid || out_ready;
	assign c = cls.c;
	assign top_ok = (lvl_q != 7'd0) && (lvl_q <= 7'(STACK_DEPTH));
	assign top_idx = SW'(lvl_q - 7'd1);
	assign kind_top = top_ok ? kind_mem[top_idx] : 1'b0;
	assign cnt_top = cnt_mem[top_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= 6'd32; max_elems_q <= 13'd4096; val_max_q <= 13'd4096;
			key_max_q <= 13'd63; num_max_q <= 9'd511;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				R_MAX_DEPTH: max_depth_q <= cfg_data[5:0];
				R_MAX_ELEMS: max_elems_q <= cfg_data;
				R_VAL_MAX:   val_max_q <= cfg_data;
				R_KEY_MAX:   key_max_q <= cfg_data;
				R_NUM_MAX:   num_max_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [13:0] lim;
		logic [1:0]  n;
		logic        is_key;
		logic [15:0] cu_n;
		logic [1:0]  w;
		logic [13:0] ecount;
		logic        do_vd;   // value done
		logic        after_c; // number end: then after-byte handling
		logic        do_after;
		logic        do_stradd;
		logic        do_close;
		logic        do_open;
		logic        open_kind;
		logic [3:0]  num_next;
		logic        do_num;
		mode_t       nmode;
		mode_d = mode_q; lvl_d = lvl_q; slen_d = slen_q; hexl_d = hexl_q; cu_d = cu_q;
		nlen_d = nlen_q; lpos_d = lpos_q; err_d = err_q;
		wr_en = 1'b0; wr_idx = SW'(lvl_q); wr_kind = 1'b0; wr_cnt = 13'd0;
		is_key = (mode_q == M_KEY) || (mode_q == M_KEY_ESC) || (mode_q == M_KEY_HEX);
		n = 2'd1; cu_n = {cu_q[11:0], cls.hex}; w = 2'(mode_q - M_LIT_T);
		do_vd = 1'b0; after_c = 1'b0; do_after = 1'b0; do_stradd = 1'b0; do_close = 1'b0;
		do_open = 1'b0; open_kind = 1'b0; do_num = 1'b0; nmode = M_NUM_INT; num_next = 4'd0;
		ecount = {1'b0, cnt_top} + 14'd1;
		lim = {1'b0, is_key ? key_max_q : val_max_q};
		if (lim > SLIM) lim = SLIM;
		if (err_q == E_NONE) begin
			case (mode_q)
				M_PRE: if (c == "{") mode_d = M_OBJ_OPEN; else if (!cls.ws) err_d = E_UNEXP;
				M_OBJ_OPEN, M_KEY_REQ: begin
					if (!cls.ws) begin
						if (mode_q == M_OBJ_OPEN && c == "}") do_close = 1'b1;
						else if (c == "\"") begin slen_d = 14'd0; mode_d = M_KEY; end
						else err_d = E_UNEXP;
					end
				end
				M_KEY, M_STR: begin
					if (c == "\"") begin
						if (is_key) mode_d = M_COLON; else do_vd = 1'b1;
					end else if (cls.ctrl) err_d = E_CTRL;
					else if (c == "\\") mode_d = mode_t'(mode_q + 5'd1);
					else do_stradd = 1'b1;
				end
				M_KEY_ESC, M_STR_ESC: begin
					if (cls.esc_simple) do_stradd = 1'b1;
					else if (c == "u") begin
						hexl_d = 3'd4; cu_d = 16'd0; mode_d = mode_t'(mode_q + 5'd1);
					end else err_d = E_ESC;
				end
				M_KEY_HEX, M_STR_HEX: begin
					if (!cls.hex_ok) err_d = E_ESC;
					else begin
						cu_d = cu_n; hexl_d = hexl_q - 3'd1;
						if (hexl_q == 3'd1) begin
							do_stradd = 1'b1;
							n = (cu_n < 16'h80) ? 2'd1 : ((cu_n < 16'h800) ? 2'd2 : 2'd3);
						end
					end
				end
				M_COLON: if (c == ":") mode_d = M_VALUE; else if (!cls.ws) err_d = E_UNEXP;
				M_VALUE, M_ARR_OPEN: begin
					if (!cls.ws) begin
						if (mode_q == M_ARR_OPEN && c == "]") do_close = 1'b1;
						else if (c == "\"") begin slen_d = 14'd0; mode_d = M_STR; end
						else if (c == "{") begin do_open = 1'b1; open_kind = 1'b0; end
						else if (c == "[") begin do_open = 1'b1; open_kind = 1'b1; end
						else if (c == "t") begin lpos_d = 3'd1; mode_d = M_LIT_T; end
						else if (c == "f") begin lpos_d = 3'd1; mode_d = M_LIT_F; end
						else if (c == "n") begin lpos_d = 3'd1; mode_d = M_LIT_N; end
						else if (c == "-") begin do_num = 1'b1; nmode = M_NUM_SIGN; end
						else if (c == "0") begin do_num = 1'b1; nmode = M_NUM_ZERO; end
						else if (cls.digit) begin do_num = 1'b1; nmode = M_NUM_INT; end
						else err_d = E_UNEXP;
						if (do_num) num_next = 4'd1;
					end
				end
				M_LIT_T, M_LIT_F, M_LIT_N: begin
					if (lpos_q < lit_len(w) && c == lit_char(w, lpos_q)) begin
						lpos_d = lpos_q + 3'd1;
						if (lpos_q + 3'd1 == lit_len(w)) do_vd = 1'b1;
					end else err_d = E_UNEXP;
				end
				M_NUM_SIGN: begin
					if (c == "0") begin do_num = 1'b1; nmode = M_NUM_ZERO; end
					else if (cls.digit) begin do_num = 1'b1; nmode = M_NUM_INT; end
					else err_d = E_UNEXP;
				end
				M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC: begin
					if (cls.digit && mode_q != M_NUM_ZERO) begin do_num = 1'b1; nmode = mode_q; end
					else if (c == "." && mode_q != M_NUM_FRAC) begin
						do_num = 1'b1; nmode = M_NUM_DOT;
					end else if (c == "e" || c == "E") begin do_num = 1'b1; nmode = M_NUM_E; end
					else begin do_vd = 1'b1; after_c = 1'b1; end
				end
				M_NUM_DOT: if (cls.digit) begin do_num = 1'b1; nmode = M_NUM_FRAC; end
					else err_d = E_UNEXP;
				M_NUM_E: begin
					if (c == "+" || c == "-") begin do_num = 1'b1; nmode = M_NUM_ESIGN; end
					else if (cls.digit) begin do_num = 1'b1; nmode = M_NUM_EXP; end
					else err_d = E_UNEXP;
				end
				M_NUM_ESIGN: if (cls.digit) begin do_num = 1'b1; nmode = M_NUM_EXP; end
					else err_d = E_UNEXP;
				M_NUM_EXP: if (cls.digit) begin do_num = 1'b1; nmode = M_NUM_EXP; end
					else begin do_vd = 1'b1; after_c = 1'b1; end
				M_AFTER: do_after = 1'b1;
				M_DONE: if (!cls.ws) err_d = E_TRAIL;
				default: err_d = E_UNEXP;
			endcase

			if (do_num) begin
				if (num_next == 4'd1) begin
					if (10'd1 > {1'b0, num_max_q}) err_d = E_NUMLONG;
					else begin nlen_d = 10'd1; mode_d = nmode; end
				end else if (nlen_q + 10'd1 > {1'b0, num_max_q}) err_d = E_NUMLONG;
				else begin nlen_d = nlen_q + 10'd1; mode_d = nmode; end
			end
			if (do_stradd) begin
				if (slen_q + 14'(n) > lim) err_d = E_STRLONG;
				else begin
					slen_d = slen_q + 14'(n);
					mode_d = is_key ? M_KEY : M_STR;
				end
			end
			if (do_open) begin
				if (lvl_q >= {1'b0, max_depth_q} || lvl_q >= 7'(STACK_DEPTH)) err_d = E_DEPTH;
				else begin
					wr_en = 1'b1; wr_idx = SW'(lvl_q); wr_kind = open_kind; wr_cnt = 13'd0;
					lvl_d = lvl_q + 7'd1;
					mode_d = open_kind ? M_ARR_OPEN : M_OBJ_OPEN;
				end
			end
			// number end: value_done then after-byte; a close from the after-byte updates the parent entry
			if (do_vd) begin
				if (top_ok) begin
					if (ecount > {1'b0, max_elems_q}) err_d = E_ELEMS;
					else begin
						wr_en = 1'b1; wr_idx = top_idx; wr_kind = kind_top;
						wr_cnt = ecount[12:0]; mode_d = M_AFTER;
					end
				end else mode_d = M_AFTER;
				if (after_c && err_d == E_NONE) do_after = 1'b1;
			end
			if (do_after && !cls.ws) begin
				if (c == ",") mode_d = kind_top ? M_VALUE : M_KEY_REQ;
				else if ((!kind_top && c == "}") || (kind_top && c == "]")) do_close = 1'b1;
				else err_d = E_UNEXP;
			end
			if (do_close) begin
				if (lvl_q == 7'd0) mode_d = M_DONE;
				else begin
					lvl_d = lvl_q - 7'd1;
					// close: count the parent element
					if (lvl_q >= 7'd2 && lvl_q - 7'd1 <= 7'(STACK_DEPTH)) begin
						if ({1'b0, cnt_mem[SW'(lvl_q - 7'd2)]} + 14'd1 > {1'b0, max_elems_q})
							err_d = E_ELEMS;
						else begin
							wr_en = 1'b1; wr_idx = SW'(lvl_q - 7'd2);
							wr_kind = kind_mem[SW'(lvl_q - 7'd2)];
							wr_cnt = cnt_mem[SW'(lvl_q - 7'd2)] + 13'd1; mode_d = M_AFTER;
						end
					end else mode_d = M_AFTER;
				end
			end
		end
		if (cls.last && err_d == E_NONE && mode_d != M_DONE) err_d = E_EARLY;
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			kind_mem[wr_idx] <= wr_kind;
			cnt_mem[wr_idx]  <= wr_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PRE; lvl_q <= '0; slen_q <= '0; hexl_q <= '0; cu_q <= '0;
			nlen_q <= '0; lpos_q <= '0; err_q <= E_NONE; out_valid <= 1'b0;
		end else begin
			if (in_ready) out_valid <= in_valid;
			if (fire) begin
				if (cls.last) begin
					mode_q <= M_PRE; lvl_q <= '0; slen_q <= '0; hexl_q <= '0; cu_q <= '0;
					nlen_q <= '0; lpos_q <= '0; err_q <= E_NONE;
				end else begin
					mode_q <= mode_d; lvl_q <= lvl_d; slen_q <= slen_d; hexl_q <= hexl_d;
					cu_q <= cu_d; nlen_q <= nlen_d; lpos_q <= lpos_d; err_q <= err_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res.verdict <= cls.last ? ((err_d != E_NONE) ? V_BAD : V_OK) : V_BUSY;
			res.err     <= err_d;
			res.depth   <= 6'(lvl_d);
			res.done    <= cls.last;
		end
	end
endmodule

// ===== rtl/strict_json_syntax_validator_top.sv =====
// Channel   | Dir | Handshake            | Payload
// in        | in  | valid / ready        | data_byte, last
// cfg       | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// out       | out | out_valid/out_ready  | verdict, error_code, nest_depth, done_res
// One byte per cycle sustained while the output is not stalled; the result is registered in front, queue and back.
// The back state machine resolves each byte against the stack top.
// Reset clears all control state; stack entries are written before they are read.
// Output stall backs up through the queue to the input.
// Top level of the strict JSON syntax validator; depends on sjv_pkg and the sjv_* modules.
module strict_json_syntax_validator_top #(
	parameter int STACK_DEPTH  = sjv_pkg::STACK_DEPTH_DEF,
	parameter int STRING_LIMIT = sjv_pkg::STRING_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [3:0]  error_code,
	output logic [5:0]  nest_depth,
	output logic        done_res
);
	import sjv_pkg::*;
	`include "assert_macros.svh"
	cls_t f_cls, q_cls;
	logic f_valid, f_ready, q_valid, q_ready;
	res_t res;

	assign cfg_ready = 1'b1;

	sjv_front u_front (.clk, .arst_n, .valid, .ready, .data_byte, .last,
		.cls_valid(f_valid), .cls_ready(f_ready), .cls(f_cls));
	sjv_fifo u_fifo (.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_cls),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_cls));
	sjv_back #(.STACK_DEPTH(STACK_DEPTH), .STRING_LIMIT(STRING_LIMIT)) u_back (
		.clk, .arst_n, .in_valid(q_valid), .in_ready(q_ready), .cls(q_cls),
		.cfg_valid, .cfg_index, .cfg_data, .out_valid, .out_ready, .res);

	assign verdict    = res.verdict;
	assign error_code = res.err;
	assign nest_depth = res.depth;
	assign done_res   = res.done;

	`CHK_IMPL(a_verdict_done, out_valid, (verdict != V_BUSY) == done_res)
	`CHK_IMPL(a_bad_has_err, out_valid && verdict == V_BAD, error_code != E_NONE)
	`CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res))
endmodule
